FILE: hw/rtl/frir_pkg.sv
`timescale 1ns / 1ps
package frir_pkg;

  // Ring depth; the stamp RAM, pointer and fill count follow from it.
  localparam int WINDOW_DEPTH = 32;
  localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

  localparam int TS_W       = 32;
  localparam int RATE_W     = 16;
  localparam int IV_W       = 10;
  localparam int TGT_W      = 7;
  localparam int GAIN_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int OUT_W      = 32;

  // Rate numerator (count-1)*1000
  localparam int RNUM_W = $clog2((WINDOW_DEPTH - 1) * 1000 + 1);

  // Adjustment datapath widths
  localparam int MAG_W  = RATE_W;
  localparam int MAG10_W = MAG_W + 4;
  localparam int P1_W   = IV_W + MAG_W;
  localparam int IVT_W  = IV_W + TGT_W;
  localparam int P2_W   = P1_W + GAIN_W;
  localparam int NUM_W  = P2_W + 1;
  localparam int DEN_W  = TGT_W + 8;

  // Shared restoring divider
  localparam int DIV_W  = NUM_W;
  localparam int REM_W  = TS_W + 1;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  // Register reset values
  localparam logic [TGT_W-1:0]  RST_TARGET   = TGT_W'(60);
  localparam logic              RST_ADAPTIVE = 1'b1;
  localparam logic [GAIN_W-1:0] RST_GAIN     = GAIN_W'(128);
  localparam logic [IV_W-1:0]   RST_MIN      = IV_W'(8);
  localparam logic [IV_W-1:0]   RST_MAX      = IV_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET   = 3'd0,
    CFG_ADAPTIVE = 3'd1,
    CFG_GAIN     = 3'd2,
    CFG_MIN      = 3'd3,
    CFG_MAX      = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_t;

  // 1000/target for every 7-bit target; a zero target counts as one
  typedef logic [IV_W-1:0] base_tab_t [2**TGT_W];

  function automatic base_tab_t build_base_tab();
    base_tab_t tab;
    int        quot;
    int        rest;
    for (int i = 0; i < 2**TGT_W; i++) begin
      // long division of 1000 by i, one bit at a time
      quot = 0;
      rest = 0;
      for (int b = IV_W - 1; b >= 0; b--) begin
        rest = (rest << 1) | ((1000 >> b) & 1);
        quot = quot << 1;
        if (i != 0 && rest >= i) begin
          rest = rest - i;
          quot = quot | 1;
        end
      end
      tab[i] = (i == 0) ? IV_W'(1000) : IV_W'(quot);
    end
    return tab;
  endfunction

  localparam base_tab_t BASE_TAB = build_base_tab();

endpackage

FILE: hw/rtl/frir_ram.sv
`timescale 1ns / 1ps
module frir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/frame_rate_interval_regulator.sv
`timescale 1ns / 1ps
// Steps: a clear goes straight to the result stage; an update with fewer than two stamps held
// passes the adjust step only; a full update may run read, rate division, saturate, adjust,
// multiply, numerator, interval division and clamp. One item at a time: the next transfer is
// taken once the result is loaded into the output register; both divisions share one
// bit-serial divider. Reset (rst, synchronous): registers to defaults, ring empty, rate 0,
// interval 1000/60 ms. The stamp RAM is not cleared; entries are read only once written.
module frame_rate_interval_regulator
  import frir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TS_W-1:0]       s_axis_tdata,   // [31:0] timestamp_ms
  input  logic                  s_axis_tuser,   // [0] opcode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,   // [15:0] measured_rate, [25:16] interval_ms,
                                                // [26] rate_valid, [27] interval_adjusted
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_READ  = 10'b00_0000_0010,
    ST_RDIV  = 10'b00_0000_0100,
    ST_RSAT  = 10'b00_0000_1000,
    ST_ADJ   = 10'b00_0001_0000,
    ST_MUL2  = 10'b00_0010_0000,
    ST_NUM   = 10'b00_0100_0000,
    ST_IDIV  = 10'b00_1000_0000,
    ST_CLAMP = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state;

  // Configuration
  logic [TGT_W-1:0]  target_rate;
  logic              adaptive_enable;
  logic [GAIN_W-1:0] gain;
  logic [IV_W-1:0]   iv_min;
  logic [IV_W-1:0]   iv_max;

  // Window and results
  logic [PTR_W-1:0]  write_ptr;
  logic [CNT_W-1:0]  fill_count;
  logic [RATE_W-1:0] rate_reg;
  logic [IV_W-1:0]   interval_reg;
  logic [IV_W-1:0]   interval_before;
  logic [TS_W-1:0]   newest;

  // Divider and multiplier registers
  logic [REM_W-1:0]  rem;
  logic [DIV_W-1:0]  quo;
  logic [TS_W-1:0]   divisor;
  logic [DCNT_W-1:0] div_cnt;
  logic [P1_W-1:0]   p1;
  logic [IVT_W-1:0]  ivt;
  logic [P2_W-1:0]   p2;
  logic              num_neg;

  // Combinational
  logic              in_accept;
  logic              upd_accept;
  logic [TGT_W-1:0]  tgt_eff;
  logic [IV_W-1:0]   base_iv;
  logic [PTR_W-1:0]  wp_inc;
  logic [CNT_W-1:0]  fill_inc;
  logic [CNT_W:0]    old_sum;
  logic [PTR_W-1:0]  oldest_idx;
  logic [TS_W-1:0]   ram_rdata;
  logic [TS_W-1:0]   dur;
  logic [RNUM_W-1:0] rnum;
  logic              diff_neg;
  logic [MAG_W-1:0]  mag;
  logic [MAG10_W-1:0] mag10;
  logic              skip_adj;
  logic [NUM_W-1:0]  ivt_ext;
  logic [NUM_W-1:0]  p2_ext;
  logic [NUM_W-1:0]  num_mag;
  logic              num_sign;
  logic [DEN_W-1:0]  den;
  logic [REM_W-1:0]  rem_sh;
  logic              fits;
  logic [REM_W-1:0]  rem_next;
  logic [DIV_W-1:0]  quo_next;
  logic [IV_W-1:0]   clamp_hi;
  logic [IV_W-1:0]   clamp_res;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign upd_accept    = in_accept && (opcode_t'(s_axis_tuser) == OP_UPDATE);

  assign tgt_eff = (target_rate == '0) ? TGT_W'(1) : target_rate;
  assign base_iv = BASE_TAB[tgt_eff];

  assign wp_inc   = (write_ptr == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : write_ptr + 1'b1;
  assign fill_inc = (fill_count == CNT_W'(WINDOW_DEPTH)) ? fill_count : fill_count + 1'b1;

  // Oldest held stamp, from the pointer and count after this write
  always_comb begin
    if ((CNT_W+1)'(wp_inc) >= (CNT_W+1)'(fill_inc)) begin
      old_sum = (CNT_W+1)'(wp_inc) - (CNT_W+1)'(fill_inc);
    end else begin
      old_sum = (CNT_W+1)'(wp_inc) + (CNT_W+1)'(WINDOW_DEPTH) - (CNT_W+1)'(fill_inc);
    end
  end
  assign oldest_idx = old_sum[PTR_W-1:0];

  frir_ram #(
    .WIDTH (TS_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_stamp_ram (
    .clk     (clk),
    .wr_en   (upd_accept),
    .wr_addr (write_ptr),
    .wr_data (s_axis_tdata),
    .rd_en   (upd_accept),
    .rd_addr (oldest_idx),
    .rd_data (ram_rdata)
  );

  assign dur  = newest - ram_rdata;
  assign rnum = RNUM_W'(({{(32-CNT_W){1'b0}}, fill_count} - 32'd1) * 32'd1000);

  // |target - rate| and the dead-band test
  always_comb begin
    diff_neg = rate_reg > RATE_W'(tgt_eff);
    mag      = diff_neg ? (rate_reg - RATE_W'(tgt_eff)) : (RATE_W'(tgt_eff) - rate_reg);
    mag10    = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};
    skip_adj = (fill_count < CNT_W'(2)) || (rate_reg == '0) || (mag10 < MAG10_W'(tgt_eff));
  end

  // Signed numerator interval*256*target + interval*diff*gain as sign and magnitude
  always_comb begin
    ivt_ext = NUM_W'({ivt, 8'b0000_0000});
    p2_ext  = NUM_W'(p2);
    if (!diff_neg) begin
      num_mag  = ivt_ext + p2_ext;
      num_sign = 1'b0;
    end else if (p2_ext > ivt_ext) begin
      num_mag  = p2_ext - ivt_ext;
      num_sign = 1'b1;
    end else begin
      num_mag  = ivt_ext - p2_ext;
      num_sign = 1'b0;
    end
  end
  assign den = {tgt_eff, 8'b0000_0000};

  // One restoring step: a quotient bit a cycle
  always_comb begin
    rem_sh   = {rem[REM_W-2:0], quo[DIV_W-1]};
    fits     = rem_sh >= {1'b0, divisor};
    rem_next = fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
    quo_next = {quo[DIV_W-2:0], fits};
  end

  // Upper bound first, then lower; a negative quotient lands on the lower bound
  always_comb begin
    clamp_hi = (quo > DIV_W'(iv_max)) ? iv_max : quo[IV_W-1:0];
    if (num_neg && (quo != '0)) begin
      clamp_res = iv_min;
    end else if (clamp_hi < iv_min) begin
      clamp_res = iv_min;
    end else begin
      clamp_res = clamp_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_rate     <= RST_TARGET;
      adaptive_enable <= RST_ADAPTIVE;
      gain            <= RST_GAIN;
      iv_min          <= RST_MIN;
      iv_max          <= RST_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TARGET:   target_rate     <= cfg_data[TGT_W-1:0];
        CFG_ADAPTIVE: adaptive_enable <= cfg_data[0];
        CFG_GAIN:     gain            <= cfg_data[GAIN_W-1:0];
        CFG_MIN:      iv_min          <= cfg_data[IV_W-1:0];
        CFG_MAX:      iv_max          <= cfg_data[IV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      write_ptr     <= '0;
      fill_count    <= '0;
      rate_reg      <= '0;
      interval_reg  <= BASE_TAB[RST_TARGET];
      m_axis_tvalid <= 1'b0;
    end else begin
      // in ST_DONE the output register is handled below
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            interval_before <= interval_reg;
            if (opcode_t'(s_axis_tuser) == OP_CLEAR) begin
              fill_count   <= '0;
              write_ptr    <= '0;
              rate_reg     <= '0;
              interval_reg <= base_iv;
              state        <= ST_DONE;
            end else begin
              newest     <= s_axis_tdata;
              write_ptr  <= wp_inc;
              fill_count <= fill_inc;
              state      <= (fill_inc >= CNT_W'(2)) ? ST_READ : ST_ADJ;
            end
          end
        end
        ST_READ: begin
          // zero duration keeps the old rate
          if (dur == '0) begin
            state <= ST_ADJ;
          end else begin
            rem     <= '0;
            quo     <= {rnum, {(DIV_W-RNUM_W){1'b0}}};
            divisor <= dur;
            div_cnt <= DCNT_W'(RNUM_W);
            state   <= ST_RDIV;
          end
        end
        ST_RDIV: begin
          rem     <= rem_next;
          quo     <= quo_next;
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == DCNT_W'(1)) begin
            state <= ST_RSAT;
          end
        end
        ST_RSAT: begin
          rate_reg <= (|quo[DIV_W-1:RATE_W]) ? '1 : quo[RATE_W-1:0];
          state    <= ST_ADJ;
        end
        ST_ADJ: begin
          if (!adaptive_enable) begin
            interval_reg <= base_iv;
            state        <= ST_DONE;
          end else if (skip_adj) begin
            state <= ST_DONE;
          end else begin
            p1    <= P1_W'(interval_reg) * P1_W'(mag);
            ivt   <= IVT_W'(interval_reg) * IVT_W'(tgt_eff);
            state <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          p2    <= P2_W'(p1) * P2_W'(gain);
          state <= ST_NUM;
        end
        ST_NUM: begin
          rem     <= '0;
          quo     <= num_mag;
          num_neg <= num_sign;
          divisor <= TS_W'(den);
          div_cnt <= DCNT_W'(DIV_W);
          state   <= ST_IDIV;
        end
        ST_IDIV: begin
          rem     <= rem_next;
          quo     <= quo_next;
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == DCNT_W'(1)) begin
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          interval_reg <= clamp_res;
          state        <= ST_DONE;
        end
        ST_DONE: begin
          // wait for the output register to be free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {4'b0000,
                              interval_reg != interval_before,
                              fill_count >= CNT_W'(2),
                              interval_reg,
                              rate_reg};
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW_DEPTH))
    else $error("fill count beyond window depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    write_ptr <= PTR_W'(WINDOW_DEPTH - 1))
    else $error("write pointer beyond window");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RDIV || state == ST_IDIV) |-> div_cnt != '0)
    else $error("divider running with zero step count");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_accept && opcode_t'(s_axis_tuser) == OP_CLEAR)
      |=> (fill_count == '0 && write_ptr == '0 && rate_reg == '0))
    else $error("clear did not empty the window");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && m_axis_tvalid && !m_axis_tready) |=> state == ST_DONE)
    else $error("result dropped while output stalled");

endmodule
